/* sv/button_gesture_classifier_assert.svh */
// assertion macros used by the classifier rtl
`ifndef BUTTON_GESTURE_CLASSIFIER_ASSERT_SVH
`define BUTTON_GESTURE_CLASSIFIER_ASSERT_SVH

// property checked on every clock outside reset
`define BGC_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition that must never be seen outside reset
`define BGC_NEVER(name, expr, msg) \
  name: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

/* sv/bgc_pkg.sv */
package bgc_pkg;

  // gesture event codes
  typedef enum logic [2:0] {
    EV_PRESS   = 3'd0,
    EV_DOUBLE  = 3'd1,
    EV_RELEASE = 3'd2,
    EV_CLICK   = 3'd3,
    EV_SHORT   = 3'd4,
    EV_HOLD    = 3'd5,
    EV_LONG    = 3'd6
  } event_t;

  // config register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_LOW = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DBL_GAP    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CLICK      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_HOLD = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_HOLD  = 3'd5;

  localparam int CFG_DATA_W = 16;

  typedef struct packed {
    logic                  active_low;
    logic [CFG_DATA_W-1:0] double_click_gap_ms;
    logic [CFG_DATA_W-1:0] click_ms;
    logic [CFG_DATA_W-1:0] short_hold_ms;
    logic [CFG_DATA_W-1:0] hold_ms;
    logic [CFG_DATA_W-1:0] long_hold_ms;
  } cfg_t;

  // events produced by one item, in emit order
  typedef struct packed {
    logic       load;
    logic [1:0] cnt;
    event_t     ev0;
    event_t     ev1;
    event_t     ev2;
  } bundle_t;

endpackage

/* sv/bgc_cfg.sv */
module bgc_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bgc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bgc_pkg::CFG_DATA_W-1:0]  cfg_data,
  output bgc_pkg::cfg_t                   cfg
);
  import bgc_pkg::*;

  cfg_t regs;

  assign cfg_ready = 1'b1;
  assign cfg       = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.active_low          <= 1'b1;
      regs.double_click_gap_ms <= 16'd300;
      regs.click_ms            <= 16'd500;
      regs.short_hold_ms       <= 16'd500;
      regs.hold_ms             <= 16'd1000;
      regs.long_hold_ms        <= 16'd3000;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ACTIVE_LOW: regs.active_low          <= cfg_data[0];
        CFG_DBL_GAP:    regs.double_click_gap_ms <= cfg_data;
        CFG_CLICK:      regs.click_ms            <= cfg_data;
        CFG_SHORT_HOLD: regs.short_hold_ms       <= cfg_data;
        CFG_HOLD:       regs.hold_ms             <= cfg_data;
        CFG_LONG_HOLD:  regs.long_hold_ms        <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

/* sv/bgc_classify.sv */
module bgc_classify #(
  parameter int TIME_WIDTH = 32
) (
  input  logic            clk,
  input  logic            rst,
  input  bgc_pkg::cfg_t   cfg,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic            command,
  input  logic [31:0]     now_ms,
  input  logic            pin_level,
  input  logic            hold_suppressed,
  input  logic            can_load,
  output bgc_pkg::bundle_t bundle
);
  import bgc_pkg::*;

  localparam int TW = TIME_WIDTH;

  // input register
  logic        item_valid;
  logic        item_command;
  logic [31:0] item_now;
  logic        item_pin;
  logic        item_suppress;

  // gesture state
  logic [TW-1:0] press_time;
  logic [TW-1:0] release_time;
  logic [2:0]    hold_reported;

  logic          accept;
  logic          move;
  logic          pressed;
  logic [TW-1:0] now_t;
  logic [TW-1:0] held;
  logic [TW-1:0] since_release;
  logic [TW-1:0] dur;
  logic          is_double;
  logic          is_click;
  logic [2:0]    fire;

  assign in_stall = item_valid && !can_load;
  assign accept   = in_valid && !in_stall;
  assign move     = item_valid && can_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (accept) begin
      item_valid <= 1'b1;
    end else if (move) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_command  <= command;
      item_now      <= now_ms;
      item_pin      <= pin_level;
      item_suppress <= hold_suppressed;
    end
  end

  assign pressed       = item_pin ^ cfg.active_low;
  assign now_t         = TW'(item_now);
  assign held          = now_t - press_time;
  assign since_release = now_t - release_time;
  assign dur           = pressed ? held : '0;
  assign is_double     = since_release < TW'(cfg.double_click_gap_ms);
  assign is_click      = held < TW'(cfg.click_ms);

  // hold thresholds, each once per press
  always_comb begin
    fire = 3'b000;
    if (item_command && !item_suppress) begin
      fire[0] = !hold_reported[0] && (dur > TW'(cfg.short_hold_ms));
      fire[1] = !hold_reported[1] && (dur > TW'(cfg.hold_ms));
      fire[2] = !hold_reported[2] && (dur > TW'(cfg.long_hold_ms));
    end
  end

  always_comb begin
    bundle.load = move;
    if (!item_command) begin
      bundle.ev0 = pressed ? EV_PRESS : EV_RELEASE;
      bundle.ev1 = pressed ? EV_DOUBLE : EV_CLICK;
      bundle.ev2 = EV_LONG;
      bundle.cnt = (pressed ? is_double : is_click) ? 2'd2 : 2'd1;
    end else begin
      // compact the fired holds in short, hold, long order
      bundle.ev0 = fire[0] ? EV_SHORT : (fire[1] ? EV_HOLD : EV_LONG);
      bundle.ev1 = (fire[0] && fire[1]) ? EV_HOLD : EV_LONG;
      bundle.ev2 = EV_LONG;
      bundle.cnt = {1'b0, fire[0]} + {1'b0, fire[1]} + {1'b0, fire[2]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      press_time    <= '0;
      release_time  <= '0;
      hold_reported <= 3'b000;
    end else if (move) begin
      if (!item_command) begin
        if (pressed) begin
          press_time    <= now_t;
          hold_reported <= 3'b000;
        end else begin
          release_time <= now_t;
        end
      end else begin
        hold_reported <= hold_reported | fire;
      end
    end
  end

endmodule

/* sv/bgc_emit.sv */
`include "button_gesture_classifier_assert.svh"

module bgc_emit (
  input  logic             clk,
  input  logic             rst,
  input  bgc_pkg::bundle_t bundle,
  output logic             can_load,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [2:0]       event_res,
  output logic             last
);
  import bgc_pkg::*;

  // three-entry shift buffer, head in ev0
  logic       valid;
  logic [1:0] cnt;
  event_t     ev0;
  event_t     ev1;
  event_t     ev2;

  logic pop;

  assign pop       = valid && !out_stall;
  assign can_load  = !valid || (pop && cnt == 2'd1);
  assign out_valid = valid;
  assign event_res = ev0;
  assign last      = (cnt == 2'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      cnt   <= 2'd0;
    end else if (bundle.load) begin
      valid <= (bundle.cnt != 2'd0);
      cnt   <= bundle.cnt;
    end else if (pop) begin
      valid <= (cnt != 2'd1);
      cnt   <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (bundle.load) begin
      ev0 <= bundle.ev0;
      ev1 <= bundle.ev1;
      ev2 <= bundle.ev2;
    end else if (pop) begin
      ev0 <= ev1;
      ev1 <= ev2;
    end
  end

  `BGC_ASSERT(a_cnt_nonzero, valid |-> (cnt != 2'd0), "buffer valid with no events")
  `BGC_NEVER(a_load_when_busy, bundle.load && !can_load, "bundle loaded over pending events")
  `BGC_ASSERT(a_keep_tail, (pop && !last && !bundle.load) |=> valid, "pending event dropped")
  `BGC_ASSERT(a_shift, (pop && !last && !bundle.load) |=> (ev0 == $past(ev1)),
              "event order broken")

endmodule

/* sv/button_gesture_classifier.sv */
// button gesture classifier: turns edge reports (command 0) and hold polls
// (command 1) for one button into press, double click, release, click
// release, short hold, hold and long hold events. each accepted word is
// classified in a single pass from the input register against the stored
// press/release times and hold flags, then its events (at most three) are
// put on the output one word per cycle while out_stall is low, last set on
// the final one. an item holds the output buffer until its last event is
// taken, so the input takes one word per cycle when items give one event
// and out_stall is low; else the next item waits in the input register. the
// first event passes the input register, then the output buffer; a poll that
// fires nothing produces no output word. configuration is to be written via
// cfg_valid/cfg_index/cfg_data (always ready) only while the block is idle;
// the block does not enforce this. timestamps are compared modulo 2^TIME_WIDTH.
module button_gesture_classifier #(
  parameter int TIME_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // input words
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        command,
  input  logic [31:0] now_ms,
  input  logic        pin_level,
  input  logic        hold_suppressed,
  // event words
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  event_res,
  output logic        last
);
  import bgc_pkg::*;

  cfg_t    cfg;
  bundle_t bundle;
  logic    can_load;

  // configuration registers
  bgc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // input register, gesture state and event classification
  bgc_classify #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_classify (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .command         (command),
    .now_ms          (now_ms),
    .pin_level       (pin_level),
    .hold_suppressed (hold_suppressed),
    .can_load        (can_load),
    .bundle          (bundle)
  );

  // output buffer, drains one event word per cycle while out_stall is low
  bgc_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .bundle    (bundle),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .event_res (event_res),
    .last      (last)
  );

endmodule

/* verif/tb_top.sv */
module tb_top;
  import bgc_pkg::*;

  // command codes carried by an input word
  localparam logic CMD_EDGE = 1'b0;
  localparam logic CMD_POLL = 1'b1;

  // cycles allowed for the whole run before it is declared hung
  localparam int CYCLE_LIMIT = 600000;
  // quiet cycles after the last expected event (pipeline plus three events)
  localparam int SETTLE_CYCLES = 12;
  localparam int WORDS_PER_PHASE = 100;

  // one expected event word
  typedef struct {
    event_t ev;
    logic   last;
  } event_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        command = 1'b0;
  logic [31:0] now_ms = '0;
  logic        pin_level = 1'b0;
  logic        hold_suppressed = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  event_res;
  logic        last;

  // mirror of the configuration registers, reset values
  logic        cfg_active_low = 1'b1;
  logic [15:0] cfg_gap_ms = 16'd300;
  logic [15:0] cfg_click_ms = 16'd500;
  logic [15:0] cfg_short_ms = 16'd500;
  logic [15:0] cfg_hold_ms = 16'd1000;
  logic [15:0] cfg_long_ms = 16'd3000;

  // mirror of the classifier state
  logic [31:0] press_stamp = '0;
  logic [31:0] release_stamp = '0;
  logic [2:0]  holds_fired = '0;  // bit0 short hold, bit1 hold, bit2 long hold

  event_word_t pending_events[$];
  int          mismatches = 0;
  int          cycles = 0;
  int          words_sent = 0;
  int          stall_left = 0;
  bit          no_idle = 1'b0;
  logic [31:0] wall_ms = '0;

  button_gesture_classifier u_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .command        (command),
    .now_ms         (now_ms),
    .pin_level      (pin_level),
    .hold_suppressed(hold_suppressed),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .event_res      (event_res),
    .last           (last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // hang guard
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d events outstanding", $time, pending_events.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // idle length: mostly none or short, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // level of the pin that counts as pressed under the current polarity
  function automatic logic down_level();
    return ~cfg_active_low;
  endfunction

  // work out the events one accepted word causes and queue them
  task automatic classify_word(input logic cmd, input logic [31:0] t, input logic pin,
                               input logic sup);
    logic        down;
    logic [31:0] since;
    logic [31:0] held;
    event_t      evs[$];
    event_word_t w;
    down = pin ^ cfg_active_low;
    if (cmd == CMD_EDGE) begin
      if (down) begin
        holds_fired = '0;
        press_stamp = t;
        evs.push_back(EV_PRESS);
        since = t - release_stamp;
        if (since < {16'd0, cfg_gap_ms}) evs.push_back(EV_DOUBLE);
      end else begin
        release_stamp = t;
        evs.push_back(EV_RELEASE);
        held = release_stamp - press_stamp;
        if (held < {16'd0, cfg_click_ms}) evs.push_back(EV_CLICK);
      end
    end else if (!sup) begin
      // a released button counts as held for zero ms
      held = down ? t - press_stamp : 32'd0;
      if (!holds_fired[0] && held > {16'd0, cfg_short_ms}) begin
        holds_fired[0] = 1'b1;
        evs.push_back(EV_SHORT);
      end
      if (!holds_fired[1] && held > {16'd0, cfg_hold_ms}) begin
        holds_fired[1] = 1'b1;
        evs.push_back(EV_HOLD);
      end
      if (!holds_fired[2] && held > {16'd0, cfg_long_ms}) begin
        holds_fired[2] = 1'b1;
        evs.push_back(EV_LONG);
      end
    end
    foreach (evs[i]) begin
      w.ev = evs[i];
      w.last = (i == evs.size() - 1);
      pending_events.push_back(w);
    end
  endtask

  // present one input word and hold it until the block takes it
  task automatic send_word(input logic cmd, input logic [31:0] t, input logic pin,
                           input logic sup);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    command         <= cmd;
    now_ms          <= t;
    pin_level       <= pin;
    hold_suppressed <= sup;
    do @(posedge clk); while (in_stall);
    classify_word(cmd, t, pin, sup);
    words_sent++;
  endtask

  // stop sending and wait for every queued event, then let the pipe go quiet
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // register write, only called while the block is idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_ACTIVE_LOW: cfg_active_low = val[0];
      CFG_DBL_GAP:    cfg_gap_ms = val;
      CFG_CLICK:      cfg_click_ms = val;
      CFG_SHORT_HOLD: cfg_short_ms = val;
      CFG_HOLD:       cfg_hold_ms = val;
      CFG_LONG_HOLD:  cfg_long_ms = val;
      default: ;
    endcase
  endtask

  task automatic write_all(input logic pol, input logic [15:0] gap, input logic [15:0] click,
                           input logic [15:0] sh, input logic [15:0] hd, input logic [15:0] lg);
    write_reg(CFG_ACTIVE_LOW, {15'd0, pol});
    write_reg(CFG_DBL_GAP, gap);
    write_reg(CFG_CLICK, click);
    write_reg(CFG_SHORT_HOLD, sh);
    write_reg(CFG_HOLD, hd);
    write_reg(CFG_LONG_HOLD, lg);
  endtask

  // event side: random stalls and the comparison against the queue
  always @(posedge clk) begin : event_check
    event_word_t want;
    int          k;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_events.size() == 0) begin
          mismatches++;
          if (mismatches <= 100)
            $display("%0t: unexpected event word, expected none, actual event %0d last %0b",
                     $time, event_res, last);
        end else begin
          want = pending_events.pop_front();
          if (event_res !== want.ev) begin
            mismatches++;
            if (mismatches <= 100)
              $display("%0t: event mismatch, expected %0d (%s), actual %0d",
                       $time, want.ev, want.ev.name(), event_res);
          end
          if (last !== want.last) begin
            mismatches++;
            if (mismatches <= 100)
              $display("%0t: last mismatch, expected %0b, actual %0b", $time, want.last, last);
          end
        end
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if ($urandom_range(0, 2) == 0) begin
        k = idle_len();
        out_stall <= (k != 0);
        stall_left = (k > 0) ? k - 1 : 0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // reset polarity and thresholds: every gesture, boundaries, repeat edges, wrap
  task automatic test_default_gestures();
    send_word(CMD_POLL, 32'd0, 1'b1, 1'b0);           // poll while released
    send_word(CMD_EDGE, 32'd1000, 1'b0, 1'b0);        // press, long after release
    send_word(CMD_POLL, 32'd1500, 1'b0, 1'b0);        // exactly at short hold, nothing
    send_word(CMD_POLL, 32'd1501, 1'b0, 1'b1);        // suppressed poll
    send_word(CMD_POLL, 32'd1501, 1'b0, 1'b0);        // short hold
    send_word(CMD_POLL, 32'd2001, 1'b0, 1'b0);        // hold
    send_word(CMD_POLL, 32'd4001, 1'b0, 1'b0);        // long hold
    send_word(CMD_POLL, 32'd9000, 1'b0, 1'b0);        // all reported already
    send_word(CMD_EDGE, 32'd9100, 1'b1, 1'b1);        // release after a long press
    send_word(CMD_EDGE, 32'd9200, 1'b0, 1'b0);        // quick re-press, double click
    send_word(CMD_EDGE, 32'd9250, 1'b0, 1'b0);        // edge with no level change
    send_word(CMD_EDGE, 32'd9300, 1'b1, 1'b0);        // click release
    send_word(CMD_EDGE, 32'd9301, 1'b1, 1'b0);        // repeated release
    send_word(CMD_EDGE, 32'd9601, 1'b0, 1'b0);        // gap exactly at limit, no double
    send_word(CMD_POLL, 32'd13000, 1'b0, 1'b0);       // all three holds in one poll
    send_word(CMD_EDGE, 32'hFFFF_FFF0, 1'b1, 1'b0);   // release near the top of time
    send_word(CMD_EDGE, 32'h0000_0010, 1'b0, 1'b0);   // press after wrap, double click
    send_word(CMD_POLL, 32'hFFFF_FFFF, 1'b0, 1'b0);   // huge duration, all holds
    send_word(CMD_EDGE, 32'h0000_0005, 1'b1, 1'b0);   // release behind press, wraps
    send_word(CMD_POLL, 32'h0000_0006, 1'b1, 1'b1);   // suppressed poll while released
    drain();
  endtask

  // zero and full scale thresholds under both polarities
  task automatic test_threshold_extremes();
    write_all(1'b0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    send_word(CMD_EDGE, 32'd100, 1'b1, 1'b0);         // press, gap 0 never doubles
    send_word(CMD_POLL, 32'd100, 1'b1, 1'b0);         // zero duration, nothing
    send_word(CMD_POLL, 32'd101, 1'b1, 1'b0);         // one ms, all three holds
    send_word(CMD_EDGE, 32'd101, 1'b0, 1'b0);         // click 0 never clicks
    send_word(CMD_POLL, 32'd5000, 1'b0, 1'b0);        // released
    drain();
    write_all(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_word(CMD_EDGE, 32'h0010_0000, 1'b0, 1'b0);
    send_word(CMD_POLL, 32'h0010_FFFF, 1'b0, 1'b0);   // exactly at threshold
    send_word(CMD_POLL, 32'h0011_0000, 1'b0, 1'b0);   // one past, all three
    send_word(CMD_EDGE, 32'h0011_0000, 1'b1, 1'b0);   // held 65536, no click
    send_word(CMD_EDGE, 32'h0011_FFFE, 1'b0, 1'b0);   // gap 65534, double
    send_word(CMD_EDGE, 32'h0012_FFFC, 1'b1, 1'b0);   // held 65534, click
    drain();
  endtask

  function automatic logic [15:0] pick_threshold();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 16'd0;
    if (r == 1) return 16'hFFFF;
    if (r < 4) return 16'($urandom);
    return 16'($urandom_range(0, 4000));
  endfunction

  function automatic logic [31:0] pick_step();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 1500);
    if (r < 95) return $urandom_range(0, 5000);
    return $urandom_range(0, 100000);
  endfunction

  // press, a few polls, release, sometimes a poll after release
  task automatic gesture_burst();
    int   polls;
    logic dn;
    dn = down_level();
    wall_ms += pick_step();
    send_word(CMD_EDGE, wall_ms, dn, 1'($urandom));
    polls = $urandom_range(0, 4);
    for (int k = 0; k < polls; k++) begin
      wall_ms += pick_step();
      send_word(CMD_POLL, wall_ms, dn, ($urandom_range(0, 7) == 0));
    end
    wall_ms += pick_step();
    send_word(CMD_EDGE, wall_ms, ~dn, 1'($urandom));
    if ($urandom_range(0, 3) == 0) begin
      wall_ms += pick_step();
      send_word(CMD_POLL, wall_ms, ~dn, 1'($urandom));
    end
  endtask

  // random configuration per phase, mostly well-formed gestures plus noise
  task automatic test_random_phases();
    int phase_start;
    for (int phase = 0; phase < 5; phase++) begin
      write_all(1'($urandom), pick_threshold(), pick_threshold(), pick_threshold(),
                pick_threshold(), pick_threshold());
      no_idle = (phase == 2);
      wall_ms = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 20000)
                                            : $urandom;
      phase_start = words_sent;
      while (words_sent - phase_start < WORDS_PER_PHASE) begin
        if ($urandom_range(0, 9) < 8) begin
          gesture_burst();
        end else begin
          send_word(1'($urandom), $urandom, 1'($urandom), 1'($urandom));
        end
        // sender holds off until everything is out, around the middle of the phase
        if (phase == 3 && words_sent - phase_start >= WORDS_PER_PHASE / 2
            && words_sent - phase_start < WORDS_PER_PHASE / 2 + 8)
          drain();
      end
      drain();
    end
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_default_gestures();
    test_threshold_extremes();
    test_random_phases();
    drain();
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
